// ===== rtl/core/fte_pkg.sv =====
// Shared types, constants and helper functions of the Fenwick tree engine.
package fte_pkg;

  localparam int TREE_SIZE = 4096;
  localparam int TREE_AW   = $clog2(TREE_SIZE);
  localparam int NODE_W    = TREE_AW + 1;
  localparam int SUM_W     = 32;
  localparam int KIND_W    = 2;
  localparam int QDEPTH    = 4;
  localparam int QAW       = $clog2(QDEPTH);

  localparam logic [NODE_W-1:0] TREE_NODES = NODE_W'(TREE_SIZE);

  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PREFIX = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIND   = 2'd2;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_PREFIX = 2'd1,
    OP_FIND   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_WALK  = 2'd2,
    ST_DONE  = 2'd3
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [NODE_W-1:0] node;
    logic [SUM_W-1:0]  operand;
  } item_t;

  typedef struct packed {
    logic q_full;
    logic clearing;
  } fstat_t;

  function automatic logic [NODE_W-1:0] low_bit(input logic [NODE_W-1:0] n);
    return n & (~n + 1'b1);
  endfunction

  function automatic logic [TREE_AW-1:0] node_addr(input logic [NODE_W-1:0] n);
    logic [NODE_W-1:0] m;
    m = n - 1'b1;
    return m[TREE_AW-1:0];
  endfunction

endpackage

// ===== rtl/core/fenwick_tree_engine.sv =====
// Top level of the Fenwick tree engine: front end, item queue and back end.
// A binary indexed tree over 4096 signed 32-bit partial sums, zeroed by a
// clearing pass after reset during which full stays high. Each item is an
// add (delta along the upward chain), a prefix read (sum along the downward
// chain, index saturated to 4096) or a find (halving-mask descent for a
// cumulative sum); every item gives exactly one result item. The front end
// classifies items into a four-entry queue, so up to four items are taken
// while the back end is busy or a result waits. The back end owns the store,
// a RAM with one read and one write port and registered read, and visits one
// tree node per cycle. An item's chain holds at most 13 nodes for add and
// find and 12 for prefix read; ignored adds, prefix reads at index zero and
// unused kind codes have none and go straight to the done state. Results
// sit in an output register until popped; the next item starts only once
// that register is free.
module fenwick_tree_engine (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  output logic                             full,
  input  logic [fte_pkg::KIND_W-1:0]       in_kind,
  input  logic [fte_pkg::NODE_W-1:0]       in_index,
  input  logic signed [fte_pkg::SUM_W-1:0] in_delta,
  input  logic signed [fte_pkg::SUM_W-1:0] in_target,
  output logic                             empty,
  input  logic                             pop,
  output logic signed [fte_pkg::SUM_W-1:0] out_prefix_sum,
  output logic [fte_pkg::NODE_W-1:0]       out_position,
  output logic                             out_found
);
  import fte_pkg::*;

  fstat_t stat;
  logic   q_push, q_full, q_pop, q_empty, clearing;
  item_t  wr_item, rd_item;

  // front end stalls on a full queue and during the clearing pass
  assign stat.q_full   = q_full;
  assign stat.clearing = clearing;

  fte_front u_front (
    .push      (push),
    .full      (full),
    .in_kind   (in_kind),
    .in_index  (in_index),
    .in_delta  (in_delta),
    .in_target (in_target),
    .stat      (stat),
    .q_push    (q_push),
    .q_item    (wr_item)
  );

  fte_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_item (wr_item),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_item (rd_item),
    .q_empty (q_empty)
  );

  // back end: tree walks, store and result register
  fte_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_item         (rd_item),
    .q_pop          (q_pop),
    .clearing       (clearing),
    .out_prefix_sum (out_prefix_sum),
    .out_position   (out_position),
    .out_found      (out_found),
    .empty          (empty),
    .pop            (pop)
  );

endmodule

// ===== rtl/core/fte_front.sv =====
// Front end: accepts items and classifies them into queue entries.
module fte_front (
  input  logic                          push,
  output logic                          full,
  input  logic [fte_pkg::KIND_W-1:0]    in_kind,
  input  logic [fte_pkg::NODE_W-1:0]    in_index,
  input  logic signed [fte_pkg::SUM_W-1:0] in_delta,
  input  logic signed [fte_pkg::SUM_W-1:0] in_target,
  input  fte_pkg::fstat_t               stat,
  output logic                          q_push,
  output fte_pkg::item_t                q_item
);
  import fte_pkg::*;

  assign full   = stat.q_full | stat.clearing;
  assign q_push = push & ~full;

  always_comb begin
    q_item.op      = OP_NONE;
    q_item.node    = '0;
    q_item.operand = '0;
    unique case (in_kind)
      KIND_ADD: begin
        // index zero or past the store: no node to touch
        if (in_index != '0 && in_index <= TREE_NODES) begin
          q_item.op = OP_ADD;
        end
        q_item.node    = in_index;
        q_item.operand = in_delta;
      end
      KIND_PREFIX: begin
        q_item.node = (in_index > TREE_NODES) ? TREE_NODES : in_index;
        if (in_index != '0) begin
          q_item.op = OP_PREFIX;
        end
      end
      KIND_FIND: begin
        q_item.op      = OP_FIND;
        q_item.node    = TREE_NODES;
        q_item.operand = in_target;
      end
      default: begin
        q_item.op = OP_NONE;
      end
    endcase
  end

endmodule

// ===== rtl/core/fte_queue.sv =====
// Small FIFO of classified items between front and back end.
module fte_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  fte_pkg::item_t wr_item,
  output logic           q_full,
  input  logic           rd_en,
  output fte_pkg::item_t rd_item,
  output logic           q_empty
);
  import fte_pkg::*;

  item_t            entry_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]     count_r, count_nxt;
  logic             do_wr, do_rd;

  assign q_full  = (count_r == (QAW+1)'(QDEPTH));
  assign q_empty = (count_r == '0);
  assign do_wr   = wr_en & ~q_full;
  assign do_rd   = rd_en & ~q_empty;
  assign rd_item = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QAW+1)'(do_wr) - (QAW+1)'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

// ===== rtl/core/fte_back.sv =====
// Back end: owns the partial-sum store, walks the tree and holds the result.
module fte_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_empty,
  input  fte_pkg::item_t                   q_item,
  output logic                             q_pop,
  output logic                             clearing,
  output logic signed [fte_pkg::SUM_W-1:0] out_prefix_sum,
  output logic [fte_pkg::NODE_W-1:0]       out_position,
  output logic                             out_found,
  output logic                             empty,
  input  logic                             pop
);
  import fte_pkg::*;

  logic [SUM_W-1:0] mem [TREE_SIZE];
  logic [SUM_W-1:0] rdata_r;
  logic [TREE_AW-1:0] rd_addr, wr_addr;
  logic [SUM_W-1:0]   wr_data;
  logic               wr_en;

  state_t             state_r, state_nxt;
  logic [TREE_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  op_t                op_r, op_nxt;
  logic [NODE_W-1:0]  cur_r, cur_nxt;
  logic [NODE_W-1:0]  base_r, base_nxt;
  logic [NODE_W-1:0]  mask_r, mask_nxt;
  logic [SUM_W-1:0]   operand_r, operand_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [NODE_W-1:0]  pos_r, pos_nxt;
  logic               hit_r, hit_nxt;
  logic               res_valid_r, res_valid_nxt;
  logic [SUM_W-1:0]   res_sum_r;
  logic [NODE_W-1:0]  res_pos_r;
  logic               res_hit_r;

  logic [NODE_W:0]    up_node;
  logic [NODE_W-1:0]  dn_node;
  logic [NODE_W-1:0]  f_base, f_mask, f_probe;
  logic [SUM_W-1:0]   f_want;

  assign clearing       = (state_r == ST_CLEAR);
  assign empty          = ~res_valid_r;
  assign out_prefix_sum = res_sum_r;
  assign out_position   = res_pos_r;
  assign out_found      = res_hit_r;

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    op_nxt      = op_r;
    cur_nxt     = cur_r;
    base_nxt    = base_r;
    mask_nxt    = mask_r;
    operand_nxt = operand_r;
    sum_nxt     = sum_r;
    pos_nxt     = pos_r;
    hit_nxt     = hit_r;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = '0;
    q_pop       = 1'b0;
    res_valid_nxt = res_valid_r & ~pop;
    up_node     = {1'b0, cur_r} + {1'b0, low_bit(cur_r)};
    dn_node     = cur_r - low_bit(cur_r);
    f_base      = base_r;
    f_want      = operand_r;
    f_mask      = mask_r >> 1;
    f_probe     = '0;
    unique case (state_r)
      ST_CLEAR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty && !res_valid_r) begin
          q_pop       = 1'b1;
          op_nxt      = q_item.op;
          cur_nxt     = q_item.node;
          operand_nxt = q_item.operand;
          base_nxt    = '0;
          mask_nxt    = TREE_NODES;
          sum_nxt     = '0;
          pos_nxt     = '0;
          hit_nxt     = 1'b0;
          rd_addr     = node_addr(q_item.node);
          state_nxt   = (q_item.op == OP_NONE) ? ST_DONE : ST_WALK;
        end
      end
      ST_WALK: begin
        unique case (op_r)
          OP_ADD: begin
            wr_en   = 1'b1;
            wr_addr = node_addr(cur_r);
            wr_data = rdata_r + operand_r;
            if (up_node <= {1'b0, TREE_NODES}) begin
              cur_nxt = up_node[NODE_W-1:0];
              rd_addr = node_addr(up_node[NODE_W-1:0]);
            end else begin
              state_nxt = ST_DONE;
            end
          end
          OP_PREFIX: begin
            sum_nxt = sum_r + rdata_r;
            if (dn_node != '0) begin
              cur_nxt = dn_node;
              rd_addr = node_addr(dn_node);
            end else begin
              state_nxt = ST_DONE;
            end
          end
          OP_FIND: begin
            if (operand_r == rdata_r) begin
              // exact node match ends the search
              pos_nxt   = cur_r;
              hit_nxt   = 1'b1;
              state_nxt = ST_DONE;
            end else begin
              if ($signed(operand_r) > $signed(rdata_r)) begin
                f_base = cur_r;
                f_want = operand_r - rdata_r;
              end
              f_probe     = f_base + f_mask;
              base_nxt    = f_base;
              mask_nxt    = f_mask;
              operand_nxt = f_want;
              if (f_mask != '0 && f_base < TREE_NODES) begin
                cur_nxt = f_probe;
                rd_addr = node_addr(f_probe);
              end else begin
                // empty remainder means the prefix ending at base matches
                hit_nxt   = (f_want == '0);
                pos_nxt   = (f_want == '0) ? f_base : '0;
                state_nxt = ST_DONE;
              end
            end
          end
          OP_NONE: begin
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_DONE: begin
        res_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      res_valid_r <= 1'b0;
      op_r        <= OP_NONE;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      res_valid_r <= res_valid_nxt;
      op_r        <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    base_r    <= base_nxt;
    mask_r    <= mask_nxt;
    operand_r <= operand_nxt;
    sum_r     <= sum_nxt;
    pos_r     <= pos_nxt;
    hit_r     <= hit_nxt;
    if (state_r == ST_DONE) begin
      res_sum_r <= sum_r;
      res_pos_r <= pos_r;
      res_hit_r <= hit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  a_walk_node: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK |-> cur_r != '0 && cur_r <= TREE_NODES)
    else $error("tree walk on a node outside the store");

  a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE |-> !res_valid_r)
    else $error("result register overwritten while still held");

  a_find_mask: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK && op_r == OP_FIND |-> $onehot(mask_r))
    else $error("find mask lost its single bit");

  a_clear_first: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> state_r == ST_CLEAR && clr_cnt_r == '0)
    else $error("store clearing pass did not start after reset");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r == ST_WALK || state_r == ST_DONE)
    else $error("queue popped without starting an item");

endmodule
